@@ rtl/gpjb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpjb_pkg
// Shared types and constants for the gamepad slot table and joystick
// update message builder.
// ----------------------------------------------------------------------------
package gpjb_pkg;

   // Default number of gamepad slots.
   localparam int SLOT_COUNT_DEFAULT = 4;

   // Command codes of an input item.
   localparam logic [1:0] CMD_MOUNT   = 2'd0;
   localparam logic [1:0] CMD_UNMOUNT = 2'd1;
   localparam logic [1:0] CMD_REPORT  = 2'd2;

   // Register indexes on the configuration port.
   localparam logic REG_TARGET_CODE   = 1'b0;
   localparam logic REG_JOYSTICK_CODE = 1'b1;

   // Message length and the index of its final byte.
   localparam int         MSG_BYTES = 7;
   localparam logic [2:0] MSG_LAST  = 3'(MSG_BYTES - 1);

   // Stick thresholds that add direction bits.
   localparam logic [7:0] STICK_HIGH = 8'hc0;
   localparam logic [7:0] STICK_LOW  = 8'h40;

   // Mapped state of one report.
   typedef struct packed {
      logic [7:0] direction_bits;
      logic [7:0] extra_bits;
      logic [7:0] scaled_x;
      logic [7:0] scaled_y;
   } report_type;

   // One slot entry of the table.
   typedef struct packed {
      logic [6:0] address;
      logic [7:0] instance_num;
      logic [3:0] joystick;
      report_type last_state;
   } slot_type;

   // Write controls from the sequencer to the slot table.
   typedef struct packed {
      logic write;
      logic mark_used;
      logic release_slot;
   } slot_write_type;

endpackage : gpjb_pkg
`default_nettype wire

@@ rtl/gamepad_report_to_joystick_bytes.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_report_to_joystick_bytes
// Gamepad slot table that turns changed gamepad reports into seven-byte
// joystick update messages.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one item per mount, unmount or gamepad report.
//   An item is taken when req_valid is high and req_stall is low; req_stall
//   stays high while an item is being worked on or its message is sent.
//   The sequencer walks the slot table one slot per cycle through a single
//   address/instance compare, up to SLOT_COUNT slots per item. Unknown
//   commands and failed reports finish in the accept cycle.
//   A changed report for a mounted pad produces seven rsp_ items: target
//   code, joystick code, joystick index, direction/fire, x, y, extra; the
//   last one carries rsp_last_byte. The first byte is offered the cycle after
//   the matching slot is found, one byte per cycle while rsp_stall is low.
//   A stalled byte holds until taken, and no new item is accepted meanwhile.
//   Reset frees all slots and clears both code registers to zero.
//   The csr_ port holds target_code at byte address 0 and joystick_code at
//   byte address 4; write them only while the block is idle.
// ----------------------------------------------------------------------------
module gamepad_report_to_joystick_bytes #(
   parameter int SLOT_COUNT = gpjb_pkg::SLOT_COUNT_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Input items
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_command,
   input  wire logic [6:0]         req_device_address,
   input  wire logic [7:0]         req_interface_instance,
   input  wire logic [3:0]         req_joystick_number,
   input  wire logic [15:0]        req_button_word,
   input  wire logic signed [15:0] req_stick_x,
   input  wire logic signed [15:0] req_stick_y,
   input  wire logic               req_report_ok,
   // Result items
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_last_byte,
   // Configuration port
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import gpjb_pkg::*;

   localparam int             IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [2:0]       byte_ff, byte_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [6:0]       addr_ff, addr_in;
   logic [7:0]       inst_ff, inst_in;
   logic [3:0]       joy_ff, joy_in;
   report_type       rep_ff, rep_in;
   logic [7:0]       target_ff, target_in;
   logic [7:0]       joycode_ff, joycode_in;

   report_type       new_report;
   logic             req_accept;
   logic             csr_write;
   logic             rd_used;
   slot_type         rd_slot;
   slot_write_type   wr_ctrl;
   slot_type         wr_slot;
   logic             match;
   logic             changed;
   logic             last_slot;

   // Button and stick mapping of the incoming item.
   gpjb_report_map u_report_map (
      .button_word (req_button_word),
      .stick_x     (req_stick_x),
      .stick_y     (req_stick_y),
      .report      (new_report)
   );

   // Slot storage, stepped through by the sequencer.
   gpjb_slot_table #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX_W      (IDX_W)
   ) u_slot_table (
      .clock   (clock),
      .reset   (reset),
      .index   (idx_ff),
      .wr_ctrl (wr_ctrl),
      .wr_slot (wr_slot),
      .rd_used (rd_used),
      .rd_slot (rd_slot)
   );

   // Handshakes.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // Configuration register writes.
   always_comb begin
      target_in  = target_ff;
      joycode_in = joycode_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_TARGET_CODE:   target_in  = csr_pwdata[7:0];
            REG_JOYSTICK_CODE: joycode_in = csr_pwdata[7:0];
            default:           target_in  = target_ff;
         endcase
      end
   end

   // Configuration register reads.
   always_comb begin
      unique case (csr_paddr[2])
         REG_TARGET_CODE:   csr_prdata = {24'h000000, target_ff};
         REG_JOYSTICK_CODE: csr_prdata = {24'h000000, joycode_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // The shared compare: slot identity and last sent state.
   assign match     = rd_used && (rd_slot.address == addr_ff) &&
                      (rd_slot.instance_num == inst_ff);
   assign changed   = (rd_slot.last_state != rep_ff);
   assign last_slot = (idx_ff == LAST_IDX);

   // Sequencer: accept, scan the slots, then send the message.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      byte_in  = byte_ff;
      cmd_in   = cmd_ff;
      addr_in  = addr_ff;
      inst_in  = inst_ff;
      joy_in   = joy_ff;
      rep_in   = rep_ff;
      wr_ctrl  = '0;
      wr_slot  = rd_slot;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in  = req_command;
               addr_in = req_device_address;
               inst_in = req_interface_instance;
               joy_in  = req_joystick_number;
               rep_in  = new_report;
               idx_in  = '0;
               if ((req_command == CMD_MOUNT) || (req_command == CMD_UNMOUNT) ||
                   ((req_command == CMD_REPORT) && req_report_ok)) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + IDX_W'(1);
            if (last_slot) begin
               state_in = ST_IDLE;
            end
            case (cmd_ff)
               CMD_MOUNT: begin
                  // First free slot takes the pad with a cleared last state.
                  if (!rd_used) begin
                     wr_ctrl.write        = 1'b1;
                     wr_ctrl.mark_used    = 1'b1;
                     wr_slot.address      = addr_ff;
                     wr_slot.instance_num = inst_ff;
                     wr_slot.joystick     = joy_ff;
                     wr_slot.last_state   = '0;
                     state_in             = ST_IDLE;
                  end
               end
               CMD_UNMOUNT: begin
                  // Every matching slot is freed.
                  if (match) begin
                     wr_ctrl.release_slot = 1'b1;
                  end
               end
               default: begin
                  // Only the first matching slot serves the report.
                  if (match) begin
                     state_in = ST_IDLE;
                     if (changed) begin
                        wr_ctrl.write      = 1'b1;
                        wr_slot.last_state = rep_ff;
                        joy_in             = rd_slot.joystick;
                        byte_in            = '0;
                        state_in           = ST_EMIT;
                     end
                  end
               end
            endcase
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               byte_in = byte_ff + 3'd1;
               if (byte_ff == MSG_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         target_ff  <= '0;
         joycode_ff <= '0;
      end else begin
         state_ff   <= state_in;
         target_ff  <= target_in;
         joycode_ff <= joycode_in;
      end
      idx_ff  <= idx_in;
      byte_ff <= byte_in;
      cmd_ff  <= cmd_in;
      addr_ff <= addr_in;
      inst_ff <= inst_in;
      joy_ff  <= joy_in;
      rep_ff  <= rep_in;
   end

   // Message byte selection; all sources hold until the byte is taken.
   assign rsp_valid     = (state_ff == ST_EMIT);
   assign rsp_last_byte = (byte_ff == MSG_LAST);
   always_comb begin
      case (byte_ff)
         3'd0:    rsp_out_byte = target_ff;
         3'd1:    rsp_out_byte = joycode_ff;
         3'd2:    rsp_out_byte = {4'h0, joy_ff};
         3'd3:    rsp_out_byte = rep_ff.direction_bits;
         3'd4:    rsp_out_byte = rep_ff.scaled_x;
         3'd5:    rsp_out_byte = rep_ff.scaled_y;
         default: rsp_out_byte = rep_ff.extra_bits;
      endcase
   end

endmodule : gamepad_report_to_joystick_bytes
`default_nettype wire

@@ rtl/gpjb_report_map.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpjb_report_map
// Maps a gamepad button word and left stick to the direction/fire byte,
// the extra-button byte and two scaled stick bytes.
// ----------------------------------------------------------------------------
module gpjb_report_map (
   input  wire logic        [15:0] button_word,
   input  wire logic signed [15:0] stick_x,
   input  wire logic signed [15:0] stick_y,
   output gpjb_pkg::report_type    report
);
   import gpjb_pkg::*;

   logic [7:0] raw_x;
   logic [7:0] raw_y;
   logic [7:0] ax;
   logic [7:0] ay;
   logic [7:0] dir;
   logic [7:0] extra;

   // Flip sign bit (half-range offset), keep high byte, lift 0 to 1, invert y.
   assign raw_x = {~stick_x[15], stick_x[14:8]};
   assign raw_y = {~stick_y[15], stick_y[14:8]};
   assign ax    = (raw_x == 8'h00) ? 8'h01 : raw_x;
   assign ay    = ~((raw_y == 8'h00) ? 8'h01 : raw_y);

   // Direction pad and fire buttons, with stick directions ORed in.
   always_comb begin
      dir      = {button_word[15:12], button_word[0], button_word[1],
                  button_word[2], button_word[3]};
      dir[0]   = dir[0] | (ax > STICK_HIGH);
      dir[1]   = dir[1] | (ax < STICK_LOW);
      dir[2]   = dir[2] | (ay > STICK_HIGH);
      dir[3]   = dir[3] | (ay < STICK_LOW);
   end

   // Shoulder, back and start buttons.
   assign extra = {2'b00, button_word[4], button_word[5], 2'b00,
                   button_word[9], button_word[8]};

   assign report.direction_bits = dir;
   assign report.extra_bits     = extra;
   assign report.scaled_x       = ax;
   assign report.scaled_y       = ay;

endmodule : gpjb_report_map
`default_nettype wire

@@ rtl/gpjb_slot_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpjb_slot_table
// Gamepad slot storage: a used bit per slot plus the slot entries, read and
// written at one index that the sequencer steps through.
// ----------------------------------------------------------------------------
module gpjb_slot_table #(
   parameter int SLOT_COUNT = gpjb_pkg::SLOT_COUNT_DEFAULT,
   parameter int IDX_W      = 2
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [IDX_W-1:0]        index,
   input  wire gpjb_pkg::slot_write_type wr_ctrl,
   input  wire gpjb_pkg::slot_type      wr_slot,
   output logic                         rd_used,
   output gpjb_pkg::slot_type           rd_slot
);
   import gpjb_pkg::*;

   logic [SLOT_COUNT-1:0] used_ff;
   logic [SLOT_COUNT-1:0] used_in;
   slot_type              slot_mem [SLOT_COUNT];

   // Read the entry at the current index.
   assign rd_used = used_ff[index];
   assign rd_slot = slot_mem[index];

   // Set or clear the used bit of the current slot.
   always_comb begin
      used_in = used_ff;
      if (wr_ctrl.mark_used) begin
         used_in[index] = 1'b1;
      end else if (wr_ctrl.release_slot) begin
         used_in[index] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // Entry storage; contents are only read for used slots.
   always_ff @(posedge clock) begin
      if (wr_ctrl.write) begin
         slot_mem[index] <= wr_slot;
      end
   end

endmodule : gpjb_slot_table
`default_nettype wire

@@ rtl/gpjb_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpjb_checker
// Port-level checks of the joystick message sequencing, bound to the top.
// ----------------------------------------------------------------------------
module gpjb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last_byte
);

   // No new item is taken while a message is being sent.
   a_stall_during_msg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("item accepted while a message is in flight");

   // A stalled byte holds its value.
   a_byte_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_byte) &&
                                    $stable(rsp_last_byte)))
      else $error("stalled message byte changed");

   // A message keeps going until its final byte.
   a_msg_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_byte) |=> rsp_valid)
      else $error("message ended before its final byte");

   // The final byte closes the message.
   a_msg_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_byte) |=> !rsp_valid)
      else $error("byte offered after the final byte");

endmodule : gpjb_checker

bind gamepad_report_to_joystick_bytes gpjb_checker u_gpjb_checker (.*);
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad slot table testbench
// Mounts, unmounts and reports gamepads while both channels idle and stall at
// random, predicts every joystick update message, and checks each output byte
// in order against that prediction under several code register settings.
// ----------------------------------------------------------------------------
module testbench;
   import gpjb_pkg::*;

   localparam int         SLOTS         = SLOT_COUNT_DEFAULT;
   localparam logic [1:0] CMD_UNUSED    = 2'd3;
   localparam int         LIMIT_CYCLES  = 200000;
   localparam int         SETTLE_CYCLES = 16;
   localparam int         RESET_CYCLES  = 7;
   localparam int         POOL_SIZE     = 6;

   // One input item as it is driven onto the req_ ports.
   typedef struct packed {
      logic [1:0]  command;
      logic [6:0]  address;
      logic [7:0]  instance_num;
      logic [3:0]  joystick;
      logic [15:0] buttons;
      logic [15:0] stick_x;
      logic [15:0] stick_y;
      logic        report_ok;
   } pad_item_type;

   // One byte of a joystick update message.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } msg_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [1:0]  req_command = '0;
   logic [6:0]  req_device_address = '0;
   logic [7:0]  req_interface_instance = '0;
   logic [3:0]  req_joystick_number = '0;
   logic [15:0] req_button_word = '0;
   logic [15:0] req_stick_x = '0;
   logic [15:0] req_stick_y = '0;
   logic        req_report_ok = 1'b0;
   logic        rsp_stall = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic        req_stall;
   logic        rsp_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_byte;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   gamepad_report_to_joystick_bytes #(.SLOT_COUNT(SLOTS)) dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_command            (req_command),
      .req_device_address     (req_device_address),
      .req_interface_instance (req_interface_instance),
      .req_joystick_number    (req_joystick_number),
      .req_button_word        (req_button_word),
      .req_stick_x            (req_stick_x),
      .req_stick_y            (req_stick_y),
      .req_report_ok          (req_report_ok),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_last_byte          (rsp_last_byte),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   always #2 clock = ~clock;

   // Predicted state of the block: code registers and the slot table.
   logic [7:0] target_copy = '0;
   logic [7:0] joystick_copy = '0;
   logic       slot_used [SLOTS];
   slot_type   slot_table [SLOTS];

   pad_item_type  pending_items [$];
   msg_byte_type  update_bytes_due [$];

   // Identities that the random items mount, report and unmount.
   logic [6:0]  pool_addr [POOL_SIZE];
   logic [7:0]  pool_inst [POOL_SIZE];
   logic [15:0] last_buttons [POOL_SIZE];
   logic [15:0] last_x [POOL_SIZE];
   logic [15:0] last_y [POOL_SIZE];

   int   cycle_count = 0;
   int   error_count = 0;
   int   items_accepted = 0;
   int   bytes_checked = 0;
   int   messages_due = 0;
   int   settings_used = 1;
   int   req_gap_left = 0;
   int   stall_left = 0;
   int   rsp_quiet_left = 0;
   logic req_taken = 1'b0;
   logic calm_phase = 1'b0;

   // Stick scaling: adding 32768 flips the sign bit, then keep the high byte.
   function automatic logic [7:0] stick_byte(logic [15:0] raw);
      logic [7:0] v;
      v = raw[15:8] ^ 8'h80;
      return (v == 8'h00) ? 8'h01 : v;
   endfunction

   // Map buttons and sticks to the four state bytes of a report.
   function automatic report_type map_report(pad_item_type it);
      report_type r;
      r.scaled_x = stick_byte(it.stick_x);
      r.scaled_y = 8'hff - stick_byte(it.stick_y);
      r.direction_bits = {it.buttons[15:12], it.buttons[0], it.buttons[1],
                          it.buttons[2], it.buttons[3]};
      r.extra_bits = {2'b00, it.buttons[4], it.buttons[5], 2'b00,
                      it.buttons[9], it.buttons[8]};
      if (r.scaled_x > STICK_HIGH) r.direction_bits[0] = 1'b1;
      if (r.scaled_x < STICK_LOW)  r.direction_bits[1] = 1'b1;
      if (r.scaled_y > STICK_HIGH) r.direction_bits[2] = 1'b1;
      if (r.scaled_y < STICK_LOW)  r.direction_bits[3] = 1'b1;
      return r;
   endfunction

   // Apply one accepted item to the slot table and queue any message bytes.
   task automatic predict_update(input pad_item_type it);
      int           found;
      report_type   now_state;
      logic [7:0]   msg [MSG_BYTES];
      msg_byte_type b;
      found = -1;
      if (it.command == CMD_MOUNT) begin
         for (int s = 0; s < SLOTS; s++)
            if (!slot_used[s] && found < 0) found = s;
         if (found >= 0) begin
            slot_used[found] = 1'b1;
            slot_table[found].address = it.address;
            slot_table[found].instance_num = it.instance_num;
            slot_table[found].joystick = it.joystick;
            slot_table[found].last_state = '0;
         end
      end else if (it.command == CMD_UNMOUNT) begin
         for (int s = 0; s < SLOTS; s++)
            if (slot_used[s] && slot_table[s].address == it.address &&
                slot_table[s].instance_num == it.instance_num)
               slot_used[s] = 1'b0;
      end else if (it.command == CMD_REPORT && it.report_ok) begin
         // Only the first matching slot is served.
         for (int s = 0; s < SLOTS; s++)
            if (slot_used[s] && found < 0 && slot_table[s].address == it.address &&
                slot_table[s].instance_num == it.instance_num)
               found = s;
         if (found >= 0) begin
            now_state = map_report(it);
            if (now_state != slot_table[found].last_state) begin
               slot_table[found].last_state = now_state;
               msg[0] = target_copy;
               msg[1] = joystick_copy;
               msg[2] = {4'h0, slot_table[found].joystick};
               msg[3] = now_state.direction_bits;
               msg[4] = now_state.scaled_x;
               msg[5] = now_state.scaled_y;
               msg[6] = now_state.extra_bits;
               for (int k = 0; k < MSG_BYTES; k++) begin
                  b.data = msg[k];
                  b.last = (k == MSG_BYTES - 1);
                  update_bytes_due.push_back(b);
               end
               messages_due++;
            end
         end
      end
   endtask

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= 10) $display("ERROR at cycle %0d: %s", cycle_count, what);
   endtask

   // Monitor: cycle limit, output byte checks, and prediction of accepted items.
   always @(posedge clock) begin : monitor
      msg_byte_type want;
      pad_item_type seen;
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d bytes still expected.",
                  cycle_count, update_bytes_due.size());
         $display("Regression FAIL");
         $finish;
      end else if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (update_bytes_due.size() == 0) begin
               flag_error($sformatf("unexpected byte %02h last %0b",
                                    rsp_out_byte, rsp_last_byte));
            end else begin
               want = update_bytes_due.pop_front();
               bytes_checked++;
               if (rsp_out_byte !== want.data)
                  flag_error($sformatf("out_byte expected %02h got %02h",
                                       want.data, rsp_out_byte));
               if (rsp_last_byte !== want.last)
                  flag_error($sformatf("last_byte expected %0b got %0b",
                                       want.last, rsp_last_byte));
            end
         end
         if (req_taken) begin
            seen.command = req_command;
            seen.address = req_device_address;
            seen.instance_num = req_interface_instance;
            seen.joystick = req_joystick_number;
            seen.buttons = req_button_word;
            seen.stick_x = req_stick_x;
            seen.stick_y = req_stick_y;
            seen.report_ok = req_report_ok;
            items_accepted++;
            predict_update(seen);
         end
      end
   end

   // Item driver: holds an item until taken, then idles in random bursts.
   always @(negedge clock) begin : item_driver
      pad_item_type next;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap_left > 0) begin
            req_valid <= 1'b0;
            req_gap_left--;
         end else if (pending_items.size() != 0) begin
            next = pending_items.pop_front();
            req_valid <= 1'b1;
            req_command <= next.command;
            req_device_address <= next.address;
            req_interface_instance <= next.instance_num;
            req_joystick_number <= next.joystick;
            req_button_word <= next.buttons;
            req_stick_x <= next.stick_x;
            req_stick_y <= next.stick_y;
            req_report_ok <= next.report_ok;
            if (!calm_phase && $urandom_range(0, 3) == 0)
               req_gap_left = $urandom_range(1, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stalls: random bursts with occasional quiet stretches.
   always @(negedge clock) begin : stall_driver
      if (reset || calm_phase) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_quiet_left > 0) begin
            rsp_quiet_left--;
         end else if (stall_left == 0) begin
            if ($urandom_range(0, 39) == 0)
               rsp_quiet_left = $urandom_range(20, 80);
            else if ($urandom_range(0, 4) == 0)
               stall_left = $urandom_range(1, 13);
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // Register write: setup cycle, then access cycle until pready, then read back.
   task automatic write_register(input logic index, input logic [7:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {24'($urandom), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (index == REG_TARGET_CODE) target_copy = value;
      else joystick_copy = value;
      @(negedge clock);
      if (csr_prdata !== {24'h000000, value})
         flag_error($sformatf("register %0d read back %08h, expected %02h",
                              index, csr_prdata, value));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Wait until every item is taken and every message byte has come out.
   task automatic wait_drain();
      while (pending_items.size() != 0 || req_valid || update_bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic pad_item_type random_fields();
      pad_item_type it;
      it.command = 2'($urandom_range(0, 3));
      it.address = 7'($urandom);
      it.instance_num = 8'($urandom);
      it.joystick = 4'($urandom);
      it.buttons = 16'($urandom);
      it.stick_x = 16'($urandom);
      it.stick_y = 16'($urandom);
      it.report_ok = 1'($urandom);
      return it;
   endfunction

   // Stick positions: full scale ends, values around the direction
   // thresholds on either axis, or anything at all.
   function automatic logic [15:0] pick_stick();
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7fff;
               2: return 16'h0000;
               default: return 16'hffff;
            endcase
         end
         1: return {(($urandom_range(0, 1) != 0) ? 8'h3e : 8'hbe) +
                    8'($urandom_range(0, 4)), 8'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic pad_item_type pad_item(logic [1:0] cmd, logic [6:0] addr,
                                             logic [7:0] inst, logic [3:0] joy,
                                             logic [15:0] btn, logic [15:0] sx,
                                             logic [15:0] sy, logic ok);
      pad_item_type it;
      it.command = cmd;
      it.address = addr;
      it.instance_num = inst;
      it.joystick = joy;
      it.buttons = btn;
      it.stick_x = sx;
      it.stick_y = sy;
      it.report_ok = ok;
      return it;
   endfunction

   // Random items: mostly reports to a small pool of pads so that slots
   // match often, some repeated reports, and a share of noise.
   task automatic add_random_items(input int count);
      pad_item_type it;
      int           pick;
      int           roll;
      for (int n = 0; n < count; n++) begin
         it = random_fields();
         pick = $urandom_range(0, POOL_SIZE - 1);
         roll = $urandom_range(0, 99);
         if (roll < 58) begin
            it.command = CMD_REPORT;
            it.address = pool_addr[pick];
            it.instance_num = pool_inst[pick];
            it.report_ok = (roll < 50);
            case ($urandom_range(0, 4))
               0: begin
                  it.buttons = last_buttons[pick];
                  it.stick_x = last_x[pick];
                  it.stick_y = last_y[pick];
               end
               1: begin
                  // Raw sticks move but the scaled bytes stay the same.
                  it.buttons = last_buttons[pick];
                  it.stick_x = {last_x[pick][15:8], 8'($urandom)};
                  it.stick_y = {last_y[pick][15:8], 8'($urandom)};
               end
               default: begin
                  if ($urandom_range(0, 7) == 0) it.buttons = '0;
                  else if ($urandom_range(0, 3) == 0)
                     it.buttons = 16'(1) << $urandom_range(0, 15);
                  it.stick_x = pick_stick();
                  it.stick_y = pick_stick();
               end
            endcase
            last_buttons[pick] = it.buttons;
            last_x[pick] = it.stick_x;
            last_y[pick] = it.stick_y;
         end else if (roll < 63) begin
            it.command = CMD_REPORT;
         end else if (roll < 77) begin
            it.command = CMD_MOUNT;
            it.address = pool_addr[pick];
            it.instance_num = pool_inst[pick];
         end else if (roll < 90) begin
            it.command = CMD_UNMOUNT;
            it.address = pool_addr[pick];
            it.instance_num = pool_inst[pick];
         end else if (roll < 94) begin
            it.command = CMD_UNUSED;
         end else begin
            it.command = CMD_UNMOUNT;
         end
         pending_items.push_back(it);
      end
   endtask

   // Change both code registers while idle, then queue a random batch.
   task automatic run_phase(input logic [7:0] tcode, input logic [7:0] jcode,
                            input int count, input logic calm);
      wait_drain();
      calm_phase = calm;
      write_register(REG_TARGET_CODE, tcode);
      write_register(REG_JOYSTICK_CODE, jcode);
      settings_used++;
      @(posedge clock);
      add_random_items(count);
   endtask

   initial begin
      for (int s = 0; s < SLOTS; s++) begin
         slot_used[s] = 1'b0;
         slot_table[s] = '0;
      end
      for (int p = 0; p < POOL_SIZE; p++) begin
         pool_addr[p] = 7'($urandom);
         pool_inst[p] = 8'($urandom);
         last_buttons[p] = '0;
         last_x[p] = '0;
         last_y[p] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items, run with both code registers at their reset value.
      // Two pads at the field extremes, then a first report with both sticks
      // fully negative, which also hits the clamp of a zero scaled value.
      pending_items.push_back(pad_item(CMD_MOUNT, 7'h00, 8'h00, 4'h0, '0, '0, '0, 1'b1));
      pending_items.push_back(pad_item(CMD_MOUNT, 7'h7f, 8'hff, 4'hf, '0, '0, '0, 1'b0));
      pending_items.push_back(pad_item(CMD_REPORT, 7'h00, 8'h00, 4'h0, 16'h0000,
                                       16'h8000, 16'h8000, 1'b1));
      // The same report again has no change and sends nothing.
      pending_items.push_back(pad_item(CMD_REPORT, 7'h00, 8'h00, 4'h0, 16'h0000,
                                       16'h8000, 16'h8000, 1'b1));
      pending_items.push_back(pad_item(CMD_REPORT, 7'h7f, 8'hff, 4'h0, 16'hffff,
                                       16'h7fff, 16'h7fff, 1'b1));
      // A failed report, a report without a matching slot, an unused command.
      pending_items.push_back(pad_item(CMD_REPORT, 7'h7f, 8'hff, 4'h0, 16'h0000,
                                       16'h0000, 16'h0000, 1'b0));
      pending_items.push_back(pad_item(CMD_REPORT, 7'h7f, 8'h00, 4'h0, 16'h1234,
                                       16'h0000, 16'h0000, 1'b1));
      pending_items.push_back(pad_item(CMD_UNUSED, 7'h00, 8'h00, 4'h3, 16'hffff,
                                       16'h1234, 16'h4321, 1'b1));
      // A duplicate mount takes a further slot; reports still go to the first.
      pending_items.push_back(pad_item(CMD_MOUNT, 7'h00, 8'h00, 4'h5, '0, '0, '0, 1'b1));
      pending_items.push_back(pad_item(CMD_REPORT, 7'h00, 8'h00, 4'h0, 16'h0000,
                                       16'h4100, 16'h4000, 1'b1));
      // Fill the table, then a mount with no free slot is dropped.
      pending_items.push_back(pad_item(CMD_MOUNT, 7'h05, 8'h09, 4'h9, '0, '0, '0, 1'b1));
      pending_items.push_back(pad_item(CMD_MOUNT, 7'h06, 8'h06, 4'h3, '0, '0, '0, 1'b1));
      pending_items.push_back(pad_item(CMD_REPORT, 7'h06, 8'h06, 4'h0, 16'h00ff,
                                       16'h0000, 16'h0000, 1'b1));
      pending_items.push_back(pad_item(CMD_REPORT, 7'h00, 8'h00, 4'h0, 16'h0000,
                                       16'hbf00, 16'hc000, 1'b1));
      // Unmount frees both copies of the first pad; a stray unmount is ignored.
      pending_items.push_back(pad_item(CMD_UNMOUNT, 7'h00, 8'h00, 4'h0, '0, '0, '0, 1'b1));
      pending_items.push_back(pad_item(CMD_REPORT, 7'h00, 8'h00, 4'h0, 16'h0001,
                                       16'h0000, 16'h0000, 1'b1));
      pending_items.push_back(pad_item(CMD_UNMOUNT, 7'h01, 8'h02, 4'h0, '0, '0, '0, 1'b1));
      // The freed first slot is reused; stick values sit on the thresholds.
      pending_items.push_back(pad_item(CMD_MOUNT, 7'h06, 8'h06, 4'h3, '0, '0, '0, 1'b1));
      pending_items.push_back(pad_item(CMD_REPORT, 7'h06, 8'h06, 4'h0, 16'h0001,
                                       16'h4000, 16'h4100, 1'b1));
      pending_items.push_back(pad_item(CMD_REPORT, 7'h06, 8'h06, 4'h0, 16'h0330,
                                       16'hc000, 16'h0000, 1'b1));
      pending_items.push_back(pad_item(CMD_REPORT, 7'h06, 8'h06, 4'h0, 16'hf00f,
                                       16'h0000, 16'h0000, 1'b1));
      pending_items.push_back(pad_item(CMD_REPORT, 7'h05, 8'h09, 4'h0, 16'h0cc0,
                                       16'hffff, 16'hffff, 1'b1));

      run_phase(8'hff, 8'h00, 45, 1'b0);
      run_phase(8'h00, 8'hff, 45, 1'b0);
      run_phase(8'($urandom), 8'($urandom), 50, 1'b0);
      run_phase(8'($urandom), 8'($urandom), 50, 1'b1);
      wait_drain();

      $display("Covered %0d input items under %0d code register settings.",
               items_accepted, settings_used);
      $display("Checked %0d output bytes of %0d predicted update messages.",
               bytes_checked, messages_due);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches in total.", error_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
